// ===== rtl/wscs_pkg.sv =====
// Shared constants and queue entry type for the whitespace and comment skipper.
package wscs_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_LINE_W      = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One accepted byte that yields results: one or two words sharing a line tag.
    typedef struct packed {
        logic                  two;
        logic [7:0]            c0;
        logic                  e0;
        logic [7:0]            c1;
        logic                  e1;
        logic [OUT_LINE_W-1:0] line;
    } entry_t;

endpackage

// ===== rtl/wscs_if.sv =====
// Handshake channels for script bytes in and token words out.
interface wscs_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wscs_result_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       out_char;
    logic [wscs_pkg::OUT_LINE_W-1:0] out_line;
    logic                             is_end;
    logic                             last_of_run;

    modport source (output valid, output out_char, output out_line, output is_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input out_line, input is_end,
                    input last_of_run, output ready);
endinterface

// ===== rtl/wscs_front.sv =====
// Front end: accepts script bytes, tracks comment mode and line count, builds queue entries.
module wscs_front #(
    parameter int LINE_BITS = wscs_pkg::LINE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    wscs_text_if.sink         text,
    input  logic              full,
    output logic              push,
    output wscs_pkg::entry_t  entry
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR
    } mode_t;

    mode_t                            mode_reg, mode_next;
    logic [LINE_BITS-1:0]             line_reg, line_next;
    logic [LINE_BITS+wscs_pkg::OUT_LINE_W-1:0] line_ext;
    logic                             accept;
    logic                             bump;
    logic                             emit;
    logic                             is_blank;
    logic [7:0]                       b;

    assign line_ext = {{wscs_pkg::OUT_LINE_W{1'b0}}, line_reg};

    always_comb
    begin
        b          = text.in_byte;
        text.ready = !full;
        accept     = text.valid && !full;
        is_blank   = (b <= wscs_pkg::CH_SPACE);
        mode_next  = mode_reg;
        bump       = 1'b0;
        emit       = 1'b0;
        entry      = '0;
        entry.c0   = b;
        entry.c1   = b;
        entry.line = line_ext[wscs_pkg::OUT_LINE_W-1:0];

        if (b == wscs_pkg::CH_NUL)
        begin
            // End of script: flush a held slash, then the end word.
            emit      = 1'b1;
            mode_next = MODE_NORMAL;
            if (mode_reg == MODE_SLASH)
            begin
                entry.two = 1'b1;
                entry.c0  = wscs_pkg::CH_SLASH;
                entry.c1  = wscs_pkg::CH_NUL;
                entry.e1  = 1'b1;
            end
            else
            begin
                entry.c0 = wscs_pkg::CH_NUL;
                entry.e0 = 1'b1;
            end
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_SLASH:
                begin
                    if (b == wscs_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (b == wscs_pkg::CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        // No comment: release the slash, then treat the byte as normal.
                        emit      = 1'b1;
                        entry.c0  = wscs_pkg::CH_SLASH;
                        mode_next = MODE_NORMAL;
                        if (is_blank)
                        begin
                            bump = (b == wscs_pkg::CH_NL);
                        end
                        else if (b == wscs_pkg::CH_SLASH)
                        begin
                            mode_next = MODE_SLASH;
                        end
                        else
                        begin
                            entry.two = 1'b1;
                            entry.c1  = b;
                        end
                    end
                end
                MODE_LINE:
                begin
                    if (b == wscs_pkg::CH_NL)
                    begin
                        bump      = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK, MODE_STAR:
                begin
                    if (mode_reg == MODE_STAR && b == wscs_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (b == wscs_pkg::CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                    else
                    begin
                        bump      = (b == wscs_pkg::CH_NL);
                        mode_next = MODE_BLOCK;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (is_blank)
                    begin
                        bump = (b == wscs_pkg::CH_NL);
                    end
                    else if (b == wscs_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            endcase
        end

        if (b == wscs_pkg::CH_NUL)
        begin
            line_next = LINE_BITS'(1);
        end
        else if (bump && (line_reg != {LINE_BITS{1'b1}}))
        begin
            line_next = line_reg + LINE_BITS'(1);
        end
        else
        begin
            line_next = line_reg;
        end

        push = emit && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            line_reg <= LINE_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== rtl/wscs_queue.sv =====
// Short entry queue between the front and back ends.
module wscs_queue #(
    parameter int DEPTH = wscs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wscs_pkg::entry_t wr_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output wscs_pkg::entry_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wscs_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/wscs_back.sv =====
// Back end: expands queue entries into result words behind an output register.
module wscs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  wscs_pkg::entry_t head,
    output logic             pop,
    wscs_result_if.source    result
);

    logic                             out_valid_reg;
    logic [7:0]                       char_reg;
    logic [wscs_pkg::OUT_LINE_W-1:0] line_reg;
    logic                             end_reg;
    logic                             last_reg;
    logic                             pend_reg;
    logic [7:0]                       pend_char_reg;
    logic                             pend_end_reg;
    logic                             load;

    assign load = !out_valid_reg || result.ready;
    // Hold the queue while the second word of an entry is still waiting.
    assign pop  = load && !pend_reg && valid;

    assign result.valid       = out_valid_reg;
    assign result.out_char    = char_reg;
    assign result.out_line    = line_reg;
    assign result.is_end      = end_reg;
    assign result.last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else
            begin
                out_valid_reg <= valid;
                pend_reg      <= valid && head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                char_reg <= pend_char_reg;
                end_reg  <= pend_end_reg;
                last_reg <= 1'b1;
            end
            else if (valid)
            begin
                char_reg      <= head.c0;
                end_reg       <= head.e0;
                last_reg      <= !head.two;
                line_reg      <= head.line;
                pend_char_reg <= head.c1;
                pend_end_reg  <= head.e1;
            end
        end
    end

endmodule

// ===== rtl/whitespace_comment_skipper_unit.sv =====
// Top level of the whitespace and comment skipper.
// Takes one script byte per cycle and keeps taking bytes while results wait downstream,
// until the entry queue fills; bytes that give no word never take a queue slot.
// Each byte gives zero, one or two result words. Blanks, control bytes and comments are
// dropped. A held slash that does not start a comment is released by the next byte and comes
// out just before it if that byte is a token byte, so that byte gives two words. A byte goes
// through the entry queue and then the output register to its first word. The sustained rate
// is one byte per cycle while results are taken, limited by the single output word per cycle
// whenever slashes are released. A zero byte yields the end word, with any held slash ahead
// of it, and returns line count and mode to their reset values.
module whitespace_comment_skipper_unit #(
    parameter int LINE_BITS   = wscs_pkg::LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = wscs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wscs_text_if.sink     text,
    wscs_result_if.source result
);

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    wscs_pkg::entry_t wr_entry;
    wscs_pkg::entry_t head;

    wscs_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .full  (full),
        .push  (push),
        .entry (wr_entry)
    );

    wscs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .full    (full),
        .pop     (pop),
        .valid   (q_valid),
        .rd_data (head)
    );

    wscs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (q_valid),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== rtl/wscs_checker.sv =====
// Port-level checks for the whitespace and comment skipper, bound to the top level.
module wscs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [7:0]                       res_char,
    input logic                             res_end,
    input logic                             res_last
);

    // A stalled word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_char) && $stable(res_end))
        else $error("result word changed while stalled");

    // The end word closes its byte's run and carries a zero character.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_end |-> res_last && (res_char == wscs_pkg::CH_NUL))
        else $error("end word malformed");

    // Only a released slash can lead a two-word run.
    a_lead_slash: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !res_end && (res_char == wscs_pkg::CH_SLASH))
        else $error("leading word of a run is not a slash");

    // The second word of a run follows right after the first is taken.
    a_second_next: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid)
        else $error("second word of a run did not follow");

endmodule

bind whitespace_comment_skipper_unit wscs_checker u_wscs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_char  (result.out_char),
    .res_end   (result.is_end),
    .res_last  (result.last_of_run)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the whitespace and comment skipper: scripted and random text.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_MARK   = -1;
    localparam int RANDOM_BYTES = 1850;

    typedef enum logic [2:0] {
        TEXT_PLAIN,
        TEXT_SLASH,
        TEXT_LINE_CMT,
        TEXT_BLOCK_CMT,
        TEXT_BLOCK_STAR
    } text_mode_t;

    typedef struct packed {
        logic [7:0]                      out_char;
        logic [wscs_pkg::OUT_LINE_W-1:0] out_line;
        logic                            is_end;
        logic                            last_of_run;
    } token_word_t;

    logic clk;
    logic rst_n;

    wscs_text_if   text_ch ();
    wscs_result_if result_ch ();

    whitespace_comment_skipper_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch.sink),
        .result (result_ch.source)
    );

    int            text_q[$];
    token_word_t   pending_words[$];
    text_mode_t    text_mode;
    logic [15:0]   cur_line;
    int            mismatch_cnt;
    int            script_bytes;
    int            burst_left;
    int            gap_left;
    int            ready_pct;
    logic [7:0]    pattern_cnt;
    token_word_t   head_word;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void bump_line();
        if (cur_line != 16'hFFFF)
            cur_line = cur_line + 16'd1;
    endfunction

    function automatic void queue_word(logic [7:0] ch, logic fin);
        token_word_t w;
        w.out_char    = ch;
        w.out_line    = cur_line;
        w.is_end      = fin;
        w.last_of_run = 1'b0;
        pending_words.push_back(w);
    endfunction

    function automatic int plain_byte(logic [7:0] b);
        if (b <= wscs_pkg::CH_SPACE)
        begin
            if (b == wscs_pkg::CH_NL)
                bump_line();
            text_mode = TEXT_PLAIN;
            return 0;
        end
        if (b == wscs_pkg::CH_SLASH)
        begin
            text_mode = TEXT_SLASH;
            return 0;
        end
        text_mode = TEXT_PLAIN;
        queue_word(b, 1'b0);
        return 1;
    endfunction

    function automatic void strip_byte(logic [7:0] b);
        int words;
        words = 0;
        if (b == wscs_pkg::CH_NUL)
        begin
            // flush a held slash ahead of the end word, then restart the script
            if (text_mode == TEXT_SLASH)
            begin
                queue_word(wscs_pkg::CH_SLASH, 1'b0);
                words++;
            end
            queue_word(wscs_pkg::CH_NUL, 1'b1);
            words++;
            text_mode = TEXT_PLAIN;
            cur_line  = 16'd1;
        end
        else
        begin
            case (text_mode) inside
                TEXT_SLASH:
                begin
                    if (b == wscs_pkg::CH_SLASH)
                        text_mode = TEXT_LINE_CMT;
                    else if (b == wscs_pkg::CH_STAR)
                        text_mode = TEXT_BLOCK_CMT;
                    else
                    begin
                        queue_word(wscs_pkg::CH_SLASH, 1'b0);
                        words = 1 + plain_byte(b);
                    end
                end
                TEXT_LINE_CMT:
                begin
                    if (b == wscs_pkg::CH_NL)
                    begin
                        bump_line();
                        text_mode = TEXT_PLAIN;
                    end
                end
                TEXT_BLOCK_CMT, TEXT_BLOCK_STAR:
                begin
                    if (text_mode == TEXT_BLOCK_STAR && b == wscs_pkg::CH_SLASH)
                        text_mode = TEXT_PLAIN;
                    else if (b == wscs_pkg::CH_STAR)
                        text_mode = TEXT_BLOCK_STAR;
                    else
                    begin
                        if (b == wscs_pkg::CH_NL)
                            bump_line();
                        text_mode = TEXT_BLOCK_CMT;
                    end
                end
                default:
                    words = plain_byte(b);
            endcase
        end
        if (words > 0)
            pending_words[pending_words.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic push_byte(int b);
        text_q.push_back(b & 8'hFF);
        script_bytes++;
    endtask

    task automatic push_piece();
        int n;
        int b;
        case ($urandom_range(0, 9)) inside
            0, 1, 2:
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte($urandom_range(8'h21, 8'hFF));
            end
            3:
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte($urandom_range(1, wscs_pkg::CH_SPACE));
            end
            4:
                push_byte(wscs_pkg::CH_NL);
            5:
            begin
                push_byte(wscs_pkg::CH_SLASH);
                push_byte(wscs_pkg::CH_SLASH);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    b = $urandom_range(1, 255);
                    push_byte((b == wscs_pkg::CH_NL) ? 8'h0B : b);
                end
                push_byte(wscs_pkg::CH_NL);
            end
            6:
            begin
                // body leans on star, slash and newline to hit the closing logic
                push_byte(wscs_pkg::CH_SLASH);
                push_byte(wscs_pkg::CH_STAR);
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    case ($urandom_range(0, 4))
                        0:       push_byte(wscs_pkg::CH_STAR);
                        1:       push_byte(wscs_pkg::CH_SLASH);
                        2:       push_byte(wscs_pkg::CH_NL);
                        default: push_byte($urandom_range(1, 255));
                    endcase
                end
                push_byte(wscs_pkg::CH_STAR);
                push_byte(wscs_pkg::CH_SLASH);
            end
            7:
            begin
                push_byte(wscs_pkg::CH_SLASH);
                push_byte($urandom_range(1, 255));
            end
            8:
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte($urandom_range(1, 255));
            end
            default:
                push_byte($urandom_range(8'h80, 8'hFF));
        endcase
    endtask

    task automatic build_random_scripts();
        int pieces;
        while (script_bytes < RANDOM_BYTES)
        begin
            pieces = $urandom_range(1, 30);
            repeat (pieces) push_piece();
            // cut some scripts off inside a comment opener
            case ($urandom_range(0, 11))
                0:
                    push_byte(wscs_pkg::CH_SLASH);
                1:
                begin
                    push_byte(wscs_pkg::CH_SLASH);
                    push_byte(wscs_pkg::CH_STAR);
                end
                2:
                begin
                    push_byte(wscs_pkg::CH_SLASH);
                    push_byte(wscs_pkg::CH_SLASH);
                end
                3:
                begin
                    push_byte(wscs_pkg::CH_SLASH);
                    push_byte(wscs_pkg::CH_STAR);
                    push_byte(wscs_pkg::CH_STAR);
                end
                default:
                    ;
            endcase
            push_byte(wscs_pkg::CH_NUL);
            if ($urandom_range(0, 7) == 0)
                text_q.push_back(DRAIN_MARK);
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.valid   <= 1'b0;
            text_ch.in_byte <= 8'h00;
            burst_left      <= 0;
            gap_left        <= 0;
            text_mode        = TEXT_PLAIN;
            cur_line         = 16'd1;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
                strip_byte(text_ch.in_byte);
            if (!text_ch.valid || text_ch.ready)
            begin
                // hold at a drain mark until every pending word is out
                if (text_q.size() != 0 && text_q[0] == DRAIN_MARK && pending_words.size() == 0)
                    void'(text_q.pop_front());
                if (gap_left > 0)
                begin
                    gap_left      <= gap_left - 1;
                    text_ch.valid <= 1'b0;
                end
                else if (text_q.size() != 0 && text_q[0] != DRAIN_MARK)
                begin
                    text_ch.valid   <= 1'b1;
                    text_ch.in_byte <= 8'(text_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_pct       <= 100;
            pattern_cnt     <= 8'd0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none, %s %02h line %0d end %b last %b",
                             $time, "actual char", result_ch.out_char, result_ch.out_line,
                             result_ch.is_end, result_ch.last_of_run);
                    mismatch_cnt++;
                end
                else
                begin
                    head_word = pending_words.pop_front();
                    check_field("out_char", 16'(head_word.out_char), 16'(result_ch.out_char));
                    check_field("out_line", head_word.out_line, result_ch.out_line);
                    check_field("is_end", 16'(head_word.is_end), 16'(result_ch.is_end));
                    check_field("last_of_run", 16'(head_word.last_of_run),
                                16'(result_ch.last_of_run));
                end
            end
            // switch the acceptance rate each time the 8-bit pattern counter wraps
            pattern_cnt <= pattern_cnt + 8'd1;
            if (pattern_cnt == 8'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pct <= 100;
                    1:       ready_pct <= 80;
                    2:       ready_pct <= 40;
                    default: ready_pct <= 15;
                endcase
            end
            result_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int guard;
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.in_byte   = 8'h00;
        result_ch.ready   = 1'b0;
        mismatch_cnt      = 0;
        script_bytes      = 0;

        // tokens, blanks, control bytes, high bytes, held slashes and both comment kinds
        push_byte(8'h61);                       // 'a'
        push_byte(wscs_pkg::CH_SPACE);
        push_byte(8'h01);
        push_byte(wscs_pkg::CH_NL);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(8'h62);                       // released slash then 'b'
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_NL);             // released slash then newline
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(8'h78);
        push_byte(wscs_pkg::CH_NL);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_STAR);
        push_byte(wscs_pkg::CH_SLASH);          // opening star does not close
        push_byte(wscs_pkg::CH_STAR);
        push_byte(wscs_pkg::CH_NL);
        push_byte(wscs_pkg::CH_STAR);
        push_byte(wscs_pkg::CH_STAR);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_NUL);            // end with a held slash
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_STAR);
        push_byte(wscs_pkg::CH_NUL);            // end inside a block comment
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_SLASH);
        push_byte(wscs_pkg::CH_NUL);            // end inside a line comment
        push_byte(wscs_pkg::CH_NUL);            // empty script
        text_q.push_back(DRAIN_MARK);

        script_bytes = 0;
        build_random_scripts();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || text_ch.valid)
            @(posedge clk);
        guard = 0;
        while (pending_words.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);

        if (pending_words.size() != 0)
        begin
            $display("%0t ns: %0d expected words never arrived", $time, pending_words.size());
            mismatch_cnt++;
        end

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wscs_pkg.sv
rtl/wscs_if.sv
rtl/wscs_front.sv
rtl/wscs_queue.sv
rtl/wscs_back.sv
rtl/whitespace_comment_skipper_unit.sv
rtl/wscs_checker.sv
verif/tb_top.sv
